// ----- design/tac_pkg.sv -----
package tac_pkg;

    // Width of the internal running total; the shown cost is clipped to 24 bits.
    localparam int CostBits = 24;
    localparam int OutBits  = 24;
    localparam int ColBits  = 12;

    localparam logic [OutBits-1:0] OUT_MAX = {OutBits{1'b1}};

    localparam logic [1:0] MV_MATCH = 2'd0;
    localparam logic [1:0] MV_DEL   = 2'd1;
    localparam logic [1:0] MV_INS   = 2'd2;

    localparam logic [1:0] REG_MISMATCH   = 2'd0;
    localparam logic [1:0] REG_GAP_OPEN   = 2'd1;
    localparam logic [1:0] REG_INS_EXTEND = 2'd2;
    localparam logic [1:0] REG_DEL_EXTEND = 2'd3;

    // One classified column as it waits between the front and the back.
    typedef struct packed {
        logic [5:0] moves;     // third, second, first from the top
        logic       bad;
        logic       has_ins;
        logic [1:0] del_cnt;
        logic [1:0] mm_cnt;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic [7:0] mismatch;
        logic [7:0] gap_open;
        logic [7:0] ins_extend;
        logic [7:0] del_extend;
    } cost_cfg_t;

endpackage

// ----- design/tac_front.sv -----
module tac_front
(
    input  logic [31:0]       s_tdata,
    input  logic              s_tlast,
    output tac_pkg::entry_t   entry
);

    logic [1:0] mv [3];
    logic [7:0] ch [3];
    logic [2:0] is_match;
    logic [2:0] is_del;
    logic [2:0] is_ins;
    logic [2:0] is_code3;
    logic [1:0] n_ins;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mv[i]       = s_tdata[2*i +: 2];
            ch[i]       = s_tdata[6 + 8*i +: 8];
            is_match[i] = (mv[i] == tac_pkg::MV_MATCH);
            is_del[i]   = (mv[i] == tac_pkg::MV_DEL);
            is_ins[i]   = (mv[i] == tac_pkg::MV_INS);
            is_code3[i] = !is_match[i] && !is_del[i] && !is_ins[i];
        end
        n_ins   = 2'({1'b0, is_ins[0]} + {1'b0, is_ins[1]} + {1'b0, is_ins[2]});
    end

    always_comb
    begin
        entry.moves   = {mv[2], mv[1], mv[0]};
        entry.bad     = (|is_code3) || (is_match == 3'b000) || (n_ins > 2'd1);
        entry.has_ins = |is_ins;
        entry.del_cnt = 2'({1'b0, is_del[0]} + {1'b0, is_del[1]} + {1'b0, is_del[2]});
        entry.last    = s_tlast;

        // Mismatches between neighboring matched characters; the pattern xyx
        // counts once.
        case (is_match)
            3'b111:
            begin
                if (ch[0] == ch[2] && ch[0] != ch[1])
                    entry.mm_cnt = 2'd1;
                else
                    entry.mm_cnt = 2'({1'b0, ch[0] != ch[1]} + {1'b0, ch[1] != ch[2]});
            end
            3'b011:  entry.mm_cnt = {1'b0, ch[0] != ch[1]};
            3'b101:  entry.mm_cnt = {1'b0, ch[0] != ch[2]};
            3'b110:  entry.mm_cnt = {1'b0, ch[1] != ch[2]};
            default: entry.mm_cnt = 2'd0;
        endcase
    end

endmodule

// ----- design/tac_queue.sv -----
module tac_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tac_pkg::entry_t   push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output tac_pkg::entry_t   pop_data
);

    tac_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- design/tac_back.sv -----
module tac_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tac_pkg::cost_cfg_t        cfg,
    input  logic                      q_valid,
    input  tac_pkg::entry_t           q_data,
    output logic                      q_pop,
    output logic [tac_pkg::OutBits-1:0] cost_out,
    output logic                      bad_out,
    output logic                      last_out,
    output logic                      out_valid,
    input  logic                      out_ready
);

    logic [5:0]                     prev_moves_reg;
    logic [5:0]                     prev_moves_next;
    logic [tac_pkg::CostBits-1:0]   total_reg;
    logic [tac_pkg::CostBits-1:0]   total_next;
    logic [tac_pkg::CostBits-1:0]   total_upd;
    logic [tac_pkg::CostBits:0]     sum;
    logic [tac_pkg::ColBits-1:0]    col_cost;
    logic [tac_pkg::ColBits-1:0]    gap_part;
    logic [tac_pkg::ColBits-1:0]    ext_part;
    logic [tac_pkg::ColBits-1:0]    mm_part;
    logic [1:0]                     gap_cnt;
    logic [2:0]                     gap_open;
    logic [1:0]                     mv;
    logic [63:0]                    total_wide;
    logic                           out_valid_reg;
    logic [tac_pkg::OutBits-1:0]    cost_reg;
    logic                           bad_reg;
    logic                           last_reg;

    localparam logic [tac_pkg::CostBits-1:0] CostMax = {tac_pkg::CostBits{1'b1}};

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign cost_out  = cost_reg;
    assign bad_out   = bad_reg;
    assign last_out  = last_reg;

    // Scales an 8-bit cost by a count of zero to three.
    function automatic logic [tac_pkg::ColBits-1:0] times_cnt(input logic [7:0] c,
                                                              input logic [1:0] n);
        logic [tac_pkg::ColBits-1:0] r;
        r = '0;
        if (n[0])
            r = r + tac_pkg::ColBits'(c);
        if (n[1])
            r = r + tac_pkg::ColBits'({c, 1'b0});
        return r;
    endfunction

    always_comb
    begin
        mv = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            mv          = q_data.moves[2*i +: 2];
            gap_open[i] = (mv != tac_pkg::MV_MATCH) && (mv != prev_moves_reg[2*i +: 2]);
        end
        gap_cnt  = 2'({1'b0, gap_open[0]} + {1'b0, gap_open[1]} + {1'b0, gap_open[2]});
        gap_part = times_cnt(cfg.gap_open, gap_cnt);
        ext_part = q_data.has_ins ? tac_pkg::ColBits'(cfg.ins_extend)
                                  : times_cnt(cfg.del_extend, q_data.del_cnt);
        mm_part  = q_data.has_ins ? '0 : times_cnt(cfg.mismatch, q_data.mm_cnt);
        col_cost = gap_part + ext_part + mm_part;

        sum = {1'b0, total_reg} + (tac_pkg::CostBits + 1)'(col_cost);
        if (q_data.bad)
            total_upd = total_reg;
        else if (sum >= {1'b0, CostMax})
            total_upd = CostMax;
        else
            total_upd = sum[tac_pkg::CostBits-1:0];

        total_wide = 64'(total_upd);

        total_next      = total_reg;
        prev_moves_next = prev_moves_reg;
        if (q_pop)
        begin
            total_next = total_upd;
            if (!q_data.bad)
                prev_moves_next = q_data.moves;
            if (q_data.last)
            begin
                total_next      = '0;
                prev_moves_next = {3{tac_pkg::MV_MATCH}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cost_reg <= (total_wide > 64'(tac_pkg::OUT_MAX)) ? tac_pkg::OUT_MAX
                                                              : total_wide[tac_pkg::OutBits-1:0];
            bad_reg  <= q_data.bad;
            last_reg <= q_data.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            total_reg      <= '0;
            prev_moves_reg <= {3{tac_pkg::MV_MATCH}};
        end
        else
        begin
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            total_reg      <= total_next;
            prev_moves_reg <= prev_moves_next;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_data.last) |=> (total_reg == '0 && prev_moves_reg == 6'd0))
        else $error("state not cleared after last column");

    a_bad_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_data.bad && !q_data.last) |=>
        (total_reg == $past(total_reg) && prev_moves_reg == $past(prev_moves_reg)))
        else $error("rejected column changed the state");

    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_data.last) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !q_pop)
        else $error("result overwritten while stalled");
`endif

endmodule

// ----- design/three_way_alignment_cost_accumulator.sv -----
// Three-sequence alignment cost accumulator with affine gap costs. Each input
// transaction is one alignment column and yields exactly one output transaction
// carrying the saturating running cost, a flag for rejected columns and the
// last-column mark; the running state clears after the last column. The block
// takes one column per clock cycle in steady state while m_tready is high: the
// front classifies the column combinationally into a two-entry queue, and the
// back folds it into the running total, so the accumulate loop through the
// total and the previous moves sets the rate. An accepted column passes the
// queue and then the output register, where its result becomes valid. While
// the output is stalled the block holds three columns (two in the queue, one
// in the output register) before s_tready drops. Configuration writes take
// effect on the next cycle and are meant for an idle block.
module three_way_alignment_cost_accumulator
(
    input  logic        clk,
    input  logic        rst_n,
    // {pad, char_third, char_second, char_first, move_third, move_second,
    //  move_first} from bit 0: move_first[1:0], move_second[3:2],
    //  move_third[5:4], char_first[13:6], char_second[21:14], char_third[29:22]
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // running_cost[23:0]
    output logic [23:0] m_tdata,
    // bad_column[0]
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    tac_pkg::entry_t    front_entry;
    tac_pkg::entry_t    q_data;
    tac_pkg::cost_cfg_t cfg_reg;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mismatch   <= 8'd1;
            cfg_reg.gap_open   <= 8'd3;
            cfg_reg.ins_extend <= 8'd1;
            cfg_reg.del_extend <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tac_pkg::REG_MISMATCH:   cfg_reg.mismatch   <= cfg_data;
                tac_pkg::REG_GAP_OPEN:   cfg_reg.gap_open   <= cfg_data;
                tac_pkg::REG_INS_EXTEND: cfg_reg.ins_extend <= cfg_data;
                tac_pkg::REG_DEL_EXTEND: cfg_reg.del_extend <= cfg_data;
                default: ;
            endcase
        end
    end

    tac_front u_front
    (
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .entry   (front_entry)
    );

    tac_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    tac_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .cost_out  (m_tdata),
        .bad_out   (m_tuser),
        .last_out  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
